### rtl/tile_dirty_region_detector_unit_defines.svh
// Assertion macros of the tile dirty-region detector RTL, used by tdrd_tile_eval.
`ifndef TILE_DIRTY_REGION_DETECTOR_UNIT_DEFINES_SVH
`define TILE_DIRTY_REGION_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on clk while out of reset.
`define TDRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included.
`define TDRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDRD_ASSERT(lbl, prop, msg)
`define TDRD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/tdrd_pkg.sv
// Types and constants of the tile dirty-region detector.
package tdrd_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned OFF_W      = 7;
  localparam int unsigned TCI_W      = 11;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned PROD_W     = 18;
  localparam int unsigned SCORE_W    = 18;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned FW_W       = 12;
  localparam int unsigned FH_W       = 12;
  localparam int unsigned TS_W       = 7;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned THR3_W     = 10;
  localparam int unsigned TSQ_W      = 14;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [FH_W-1:0]   FRAME_HEIGHT_MAX = 12'd2048;
  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 12'd1024;
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 12'd768;
  localparam logic [TS_W-1:0]   RST_TILE_SIZE    = 7'd16;
  localparam logic [THR3_W-1:0] RST_THR3         = 10'd30;
  localparam logic [TSQ_W-1:0]  RST_TILE_SQ      = 14'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH      = 2'd0,
    CFG_FRAME_HEIGHT     = 2'd1,
    CFG_TILE_SIZE        = 2'd2,
    CFG_MOTION_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             frame_start;
    logic [PIX_W-1:0] cur_blue;
    logic [PIX_W-1:0] cur_green;
    logic [PIX_W-1:0] cur_red;
    logic [PIX_W-1:0] old_blue;
    logic [PIX_W-1:0] old_green;
    logic [PIX_W-1:0] old_red;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] region_x;
    logic [COORD_W-1:0] region_y;
    logic [CNT_W-1:0]   changed_count;
  } out_item_t;

  // Clamped working copies of the configuration registers.
  typedef struct packed {
    logic [FW_W-1:0]   width;
    logic [FH_W-1:0]   height;
    logic [TS_W-1:0]   tile;
    logic [THR3_W-1:0] thr3;
    logic [TSQ_W-1:0]  tile_sq;
  } cfg_t;

  // One pixel after position tracking and change detection.
  typedef struct packed {
    logic [TCI_W-1:0] tci;
    logic             first;
    logic             last;
    logic             changed;
    logic [ROW_W-1:0] origin_y;
  } pix_item_t;

endpackage

### rtl/tdrd_front.sv
// Raster position tracking and per-pixel change detection (first stage).
module tdrd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 adv,
  input  tdrd_pkg::in_item_t   in_data,
  input  tdrd_pkg::cfg_t       cfg,
  output logic                 s1_valid,
  output tdrd_pkg::pix_item_t  s1_item
);

  logic [tdrd_pkg::COL_W-1:0] col_r, col_nxt, col_e;
  logic [tdrd_pkg::ROW_W-1:0] row_r, row_nxt, row_e;
  logic [tdrd_pkg::OFF_W-1:0] offx_r, offx_nxt, offx_e;
  logic [tdrd_pkg::OFF_W-1:0] offy_r, offy_nxt, offy_e;
  logic [tdrd_pkg::TCI_W-1:0] tci_r, tci_nxt, tci_e;
  logic [tdrd_pkg::OFF_W:0]   offx_inc, offy_inc, tile_ext;
  logic [tdrd_pkg::SUM_W-1:0] sum;
  logic                       col_wrap, row_wrap, offx_wrap, offy_wrap;
  logic                       s1_valid_r;
  tdrd_pkg::pix_item_t        s1_item_r, s1_item_nxt;

  function automatic logic [tdrd_pkg::PIX_W-1:0] abs_diff(
    input logic [tdrd_pkg::PIX_W-1:0] a,
    input logic [tdrd_pkg::PIX_W-1:0] b
  );
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    // A frame start pixel restarts the raster before it is used.
    col_e  = in_data.frame_start ? '0 : col_r;
    row_e  = in_data.frame_start ? '0 : row_r;
    offx_e = in_data.frame_start ? '0 : offx_r;
    offy_e = in_data.frame_start ? '0 : offy_r;
    tci_e  = in_data.frame_start ? '0 : tci_r;

    offx_inc = {1'b0, offx_e} + 1'b1;
    offy_inc = {1'b0, offy_e} + 1'b1;
    tile_ext = {1'b0, cfg.tile};

    col_wrap  = ({1'b0, col_e} + 1'b1) >= {1'b0, cfg.width};
    row_wrap  = ({1'b0, row_e} + 1'b1) >= cfg.height;
    offx_wrap = offx_inc >= tile_ext;
    offy_wrap = offy_inc >= tile_ext;

    col_nxt  = col_e;
    row_nxt  = row_e;
    offx_nxt = offx_e;
    offy_nxt = offy_e;
    tci_nxt  = tci_e;
    if (col_wrap) begin
      col_nxt  = '0;
      offx_nxt = '0;
      tci_nxt  = '0;
      if (row_wrap) begin
        row_nxt  = '0;
        offy_nxt = '0;
      end else begin
        row_nxt  = row_e + 1'b1;
        offy_nxt = offy_wrap ? '0 : offy_inc[tdrd_pkg::OFF_W-1:0];
      end
    end else begin
      col_nxt = col_e + 1'b1;
      if (offx_wrap) begin
        offx_nxt = '0;
        tci_nxt  = tci_e + 1'b1;
      end else begin
        offx_nxt = offx_inc[tdrd_pkg::OFF_W-1:0];
      end
    end

    sum = tdrd_pkg::SUM_W'(abs_diff(in_data.cur_blue, in_data.old_blue))
        + tdrd_pkg::SUM_W'(abs_diff(in_data.cur_green, in_data.old_green))
        + tdrd_pkg::SUM_W'(abs_diff(in_data.cur_red, in_data.old_red));

    s1_item_nxt.tci     = tci_e;
    s1_item_nxt.first   = (offx_e == '0) && (offy_e == '0);
    s1_item_nxt.last    = (offx_inc == tile_ext) && (offy_inc == tile_ext);
    s1_item_nxt.changed = sum > cfg.thr3;
    s1_item_nxt.origin_y = (row_e >= tdrd_pkg::ROW_W'(offy_e)) ?
                           (row_e - tdrd_pkg::ROW_W'(offy_e)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      offx_r     <= '0;
      offy_r     <= '0;
      tci_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        offx_r <= offx_nxt;
        offy_r <= offy_nxt;
        tci_r  <= tci_nxt;
      end
      if (adv) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

### rtl/tdrd_count_ram.sv
// Per-tile-column changed-pixel count memory with write-first read register.
module tdrd_count_ram #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [tdrd_pkg::CNT_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [tdrd_pkg::CNT_W-1:0] wr_data
);

  logic [tdrd_pkg::CNT_W-1:0] mem [DEPTH];
  logic [tdrd_pkg::CNT_W-1:0] rd_data_r;

  // A read that meets a write to the same entry returns the new value.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tdrd_tile_eval.sv
// Tile bounds, count read-modify-write, dirty test and output register.
`include "tile_dirty_region_detector_unit_defines.svh"

module tdrd_tile_eval #(
  parameter int unsigned MAX_FRAME_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tdrd_pkg::cfg_t                    cfg,
  input  logic                              s1_valid,
  input  tdrd_pkg::pix_item_t               s1_item,
  output logic                              adv,
  output logic                              rd_en,
  output logic [$clog2(MAX_FRAME_WIDTH)-1:0] rd_addr,
  input  logic [tdrd_pkg::CNT_W-1:0]        rd_data,
  output logic                              wr_en,
  output logic [$clog2(MAX_FRAME_WIDTH)-1:0] wr_addr,
  output logic [tdrd_pkg::CNT_W-1:0]        wr_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tdrd_pkg::out_item_t               out_data
);

  localparam int unsigned ADDR_W = $clog2(MAX_FRAME_WIDTH);

  // Second stage: product and bounds, count read in flight.
  logic                          v2_r;
  logic [tdrd_pkg::PROD_W-1:0]   prod2_r;
  logic                          y_ok2_r, x_lim2_r, first2_r, last2_r, changed2_r;
  logic [ADDR_W-1:0]             addr2_r;
  logic [tdrd_pkg::ROW_W-1:0]    oy2_r;
  // Third stage: updated count of a completed tile.
  logic                          v3_r;
  logic [tdrd_pkg::CNT_W-1:0]    cnt3_r;
  logic [tdrd_pkg::COORD_W-1:0]  rx3_r, ry3_r;
  // Output register.
  logic                          out_valid_r;
  tdrd_pkg::out_item_t           out_data_r;

  logic [tdrd_pkg::PROD_W-1:0]   prod1;
  logic                          y_ok1, x_lim1;
  logic                          whole2;
  logic [tdrd_pkg::CNT_W-1:0]    cnt2;
  logic [tdrd_pkg::SCORE_W-1:0]  score3;
  logic                          emit3;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    prod1  = tdrd_pkg::PROD_W'(s1_item.tci) * tdrd_pkg::PROD_W'(cfg.tile);
    y_ok1  = (tdrd_pkg::FH_W'(s1_item.origin_y) + tdrd_pkg::FH_W'(cfg.tile)) <= cfg.height;
    x_lim1 = 32'(s1_item.tci) < MAX_FRAME_WIDTH;

    whole2 = x_lim2_r && y_ok2_r &&
             (({1'b0, prod2_r} + (tdrd_pkg::PROD_W + 1)'(cfg.tile)) <=
              (tdrd_pkg::PROD_W + 1)'(cfg.width));
    cnt2   = first2_r ? tdrd_pkg::CNT_W'(changed2_r)
                      : rd_data + tdrd_pkg::CNT_W'(changed2_r);

    // count * 20 against tile_size squared: the exact 5 percent test.
    score3 = (tdrd_pkg::SCORE_W'(cnt3_r) << 4) + (tdrd_pkg::SCORE_W'(cnt3_r) << 2);
    emit3  = v3_r && (score3 > tdrd_pkg::SCORE_W'(cfg.tile_sq));
  end

  assign rd_en   = adv && s1_valid;
  assign rd_addr = ADDR_W'(s1_item.tci);
  assign wr_en   = adv && v2_r && whole2;
  assign wr_addr = addr2_r;
  assign wr_data = cnt2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v2_r        <= s1_valid;
      v3_r        <= v2_r && whole2 && last2_r;
      out_valid_r <= emit3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2_r    <= prod1;
      y_ok2_r    <= y_ok1;
      x_lim2_r   <= x_lim1;
      first2_r   <= s1_item.first;
      last2_r    <= s1_item.last;
      changed2_r <= s1_item.changed;
      addr2_r    <= ADDR_W'(s1_item.tci);
      oy2_r      <= s1_item.origin_y;
      cnt3_r     <= cnt2;
      rx3_r      <= prod2_r[tdrd_pkg::COORD_W-1:0];
      ry3_r      <= tdrd_pkg::COORD_W'(oy2_r);
      out_data_r.region_x      <= rx3_r;
      out_data_r.region_y      <= ry3_r;
      out_data_r.changed_count <= cnt3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TDRD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "out_valid after reset")
  `TDRD_ASSERT(a_fwd_same_entry, $past(wr_en) && $past(rd_en) && ($past(wr_addr) == $past(rd_addr)) |-> rd_data == $past(wr_data), "count forwarding missed")
  `TDRD_ASSERT(a_wr_in_range, wr_en |-> 32'(wr_addr) < MAX_FRAME_WIDTH, "count write beyond tile columns")
  `TDRD_ASSERT(a_result_from_tile, $rose(out_valid_r) |-> $past(v3_r), "result without completed tile")
  `TDRD_ASSERT(a_result_nonzero, out_valid_r |-> out_data_r.changed_count != '0, "dirty tile with no changed pixel")

endmodule

### rtl/tile_dirty_region_detector_unit.sv
// Top level of the tile dirty-region detector: config registers and pipeline.
// Result path: a dirty tile's result passes from the stage-one register through stages two
//   and three into the output register once the tile's bottom-right pixel is accepted.
// Throughput: one pixel beat per cycle unless a stalled output result holds the pipeline.
// Reset (synchronous, rst_n low): registers return to 1024 x 768, tile 16, threshold 10,
//   raster position to zero, pipeline and output empty; the count memory is not cleared.
module tile_dirty_region_detector_unit #(
  parameter int unsigned MAX_FRAME_WIDTH = 2048,
  parameter int unsigned MAX_TILE_SIZE   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tdrd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tdrd_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [tdrd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tdrd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(MAX_FRAME_WIDTH);

  // The stored register values are already clamped to their working ranges, so
  // the datapath never sees a zero size or a size above the supported maximum.
  logic [tdrd_pkg::FW_W-1:0]   width_r;
  logic [tdrd_pkg::FH_W-1:0]   height_r;
  logic [tdrd_pkg::TS_W-1:0]   tile_r;
  logic [tdrd_pkg::THR3_W-1:0] thr3_r;
  logic [tdrd_pkg::TSQ_W-1:0]  tile_sq_r;

  logic [tdrd_pkg::FW_W-1:0]   width_nxt;
  logic [tdrd_pkg::FH_W-1:0]   height_nxt;
  logic [tdrd_pkg::TS_W-1:0]   tile_nxt;
  logic [tdrd_pkg::THR3_W-1:0] thr3_nxt;
  logic [tdrd_pkg::TSQ_W-1:0]  tile_sq_nxt;
  logic [tdrd_pkg::THR_W-1:0]  thr_in;

  tdrd_pkg::cfg_t              cfg;
  tdrd_pkg::pix_item_t         s1_item;
  logic                        s1_valid;
  logic                        adv;
  logic                        accept;
  logic                        rd_en, wr_en;
  logic [ADDR_W-1:0]           rd_addr, wr_addr;
  logic [tdrd_pkg::CNT_W-1:0]  rd_data, wr_data;

  always_comb begin
    width_nxt = cfg_wdata[tdrd_pkg::FW_W-1:0];
    if (width_nxt == '0) begin
      width_nxt = tdrd_pkg::FW_W'(1);
    end else if (32'(width_nxt) > MAX_FRAME_WIDTH) begin
      width_nxt = tdrd_pkg::FW_W'(MAX_FRAME_WIDTH);
    end

    height_nxt = cfg_wdata[tdrd_pkg::FH_W-1:0];
    if (height_nxt == '0) begin
      height_nxt = tdrd_pkg::FH_W'(1);
    end else if (height_nxt > tdrd_pkg::FRAME_HEIGHT_MAX) begin
      height_nxt = tdrd_pkg::FRAME_HEIGHT_MAX;
    end

    tile_nxt = cfg_wdata[tdrd_pkg::TS_W-1:0];
    if (tile_nxt == '0) begin
      tile_nxt = tdrd_pkg::TS_W'(1);
    end else if (32'(tile_nxt) > MAX_TILE_SIZE) begin
      tile_nxt = tdrd_pkg::TS_W'(MAX_TILE_SIZE);
    end
    // Squared tile edge is kept ready for the dirty test.
    tile_sq_nxt = tdrd_pkg::TSQ_W'(tile_nxt) * tdrd_pkg::TSQ_W'(tile_nxt);

    // The threshold is only ever used tripled.
    thr_in   = cfg_wdata[tdrd_pkg::THR_W-1:0];
    thr3_nxt = tdrd_pkg::THR3_W'(thr_in) + tdrd_pkg::THR3_W'({thr_in, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= tdrd_pkg::RST_FRAME_WIDTH;
      height_r  <= tdrd_pkg::RST_FRAME_HEIGHT;
      tile_r    <= tdrd_pkg::RST_TILE_SIZE;
      tile_sq_r <= tdrd_pkg::RST_TILE_SQ;
      thr3_r    <= tdrd_pkg::RST_THR3;
    end else if (cfg_we) begin
      unique case (tdrd_pkg::cfg_idx_t'(cfg_idx))
        tdrd_pkg::CFG_FRAME_WIDTH: begin
          width_r <= width_nxt;
        end
        tdrd_pkg::CFG_FRAME_HEIGHT: begin
          height_r <= height_nxt;
        end
        tdrd_pkg::CFG_TILE_SIZE: begin
          tile_r    <= tile_nxt;
          tile_sq_r <= tile_sq_nxt;
        end
        tdrd_pkg::CFG_MOTION_THRESHOLD: begin
          thr3_r <= thr3_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.width   = width_r;
  assign cfg.height  = height_r;
  assign cfg.tile    = tile_r;
  assign cfg.thr3    = thr3_r;
  assign cfg.tile_sq = tile_sq_r;

  // The whole pipeline moves together; it only holds while a finished result
  // sits in the output register and the downstream side stalls it.
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Stage one: raster position, tile offsets and the changed-pixel decision.
  tdrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .adv      (adv),
    .in_data  (in_data),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // One count per tile column; a tile row reuses the entry of each column.
  tdrd_count_ram #(
    .DEPTH (MAX_FRAME_WIDTH)
  ) u_count_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Stages two and three plus the output register: tile bounds, count update
  // and the five percent dirty test.
  tdrd_tile_eval #(
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH)
  ) u_tile_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .adv       (adv),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
